FILE: rtl/eadsr_pkg.sv
// Shared types, constants and codes of the exponential ADSR envelope unit.
`timescale 1ns / 1ps

package eadsr_pkg;

  localparam int StageW    = 3;
  localparam int LevelW    = 25;   // Q1.24 level
  localparam int OutLevelW = 17;   // Q1.16 level
  localparam int FactorW   = 32;   // signed Q4.28
  localparam int TimeW     = 16;
  localparam int RateW     = 18;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 18;
  localparam int NormW     = 31;   // mantissa in [2^30, 2^31)
  localparam int PosW      = 5;    // leading-one position 0..24
  localparam int FracW     = 24;
  localparam int LogW      = 30;   // signed log2, 6 integer + 24 fraction bits
  localparam int MagW      = 29;
  localparam int DivW      = 33;   // dividend and quotient bits
  localparam int StepW     = 6;
  localparam int SqSteps   = 24;
  localparam int NumStages = 5;

  localparam logic [PosW-1:0]    PosTop = PosW'(24);
  localparam logic [29:0]        Ln2Q30 = 30'd744261118;
  localparam logic [LevelW-1:0]  OneQ24 = LevelW'(1) << 24;
  localparam logic [FactorW-1:0] OneQ28 = FactorW'(1) << 28;

  typedef enum logic [StageW-1:0] {
    STG_OFF     = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_RATE    = 3'd4,
    REG_MIN     = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ENTER,
    DP_LOAD_END,
    DP_NORM,
    DP_SQUARE,
    DP_LOAD_START,
    DP_SCALE,
    DP_DIV,
    DP_FACTOR,
    DP_TICK
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENTER,
    S_CHECK,
    S_NORM_E,
    S_SQ_E,
    S_LOAD_S,
    S_NORM_S,
    S_SQ_S,
    S_SCALE,
    S_DIV,
    S_FACT,
    S_TICK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    stage_e stage;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic   norm_done;
    logic   ramp_trivial;
    logic   at_end;
    logic   timed;
    stage_e stage;
  } dp_status_t;

endpackage

FILE: rtl/eadsr_if.sv
// Handshake channels of the envelope unit: input items, result items, register writes.
`timescale 1ns / 1ps

interface eadsr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [eadsr_pkg::StageW-1:0]      target_stage;
  modport source (output valid, cmd, target_stage, input ready);
  modport sink   (input valid, cmd, target_stage, output ready);
endinterface

interface eadsr_out_if;
  logic                              valid;
  logic                              ready;
  logic [eadsr_pkg::OutLevelW-1:0]   level;
  logic [eadsr_pkg::StageW-1:0]      stage_now;
  modport source (output valid, level, stage_now, input ready);
  modport sink   (input valid, level, stage_now, output ready);
endinterface

interface eadsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [eadsr_pkg::CfgIdxW-1:0]     index;
  logic [eadsr_pkg::CfgDataW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/eadsr_dp.sv
// Envelope datapath: registers, stage entry, log2 unit, divider and level multiply.
`timescale 1ns / 1ps

module eadsr_dp #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eadsr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [eadsr_pkg::CfgDataW-1:0]      cfg_data_i,
  input  eadsr_pkg::dp_cmd_t                  cmd_i,
  output eadsr_pkg::dp_status_t               status_o,
  output logic [eadsr_pkg::OutLevelW-1:0]     level_o,
  output logic [eadsr_pkg::StageW-1:0]        stage_now_o
);

  localparam int NW = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;
  localparam logic [NW:0] CountLimit = (NW + 1)'(1) << COUNT_WIDTH;

  // configuration registers
  logic [eadsr_pkg::TimeW-1:0] attack_q, decay_q, sustain_q, release_q, min_q;
  logic [eadsr_pkg::RateW-1:0] rate_q;

  // architectural state
  eadsr_pkg::stage_e                stage_q;
  logic [COUNT_WIDTH-1:0]           count_q, len_q;
  logic [eadsr_pkg::LevelW-1:0]     level_q;
  logic [eadsr_pkg::FactorW-1:0]    factor_q;

  // ramp work registers
  logic [eadsr_pkg::LevelW-1:0]     end_q;
  logic [eadsr_pkg::NormW-1:0]      w_q;
  logic [eadsr_pkg::PosW-1:0]       p_q;
  logic [eadsr_pkg::FracW-1:0]      frac_q;
  logic signed [eadsr_pkg::LogW-1:0] log_end_q;
  logic                             neg_q;
  logic [eadsr_pkg::DivW-1:0]       dq_q;
  logic [COUNT_WIDTH-1:0]           rem_q;

  // result register
  logic [eadsr_pkg::OutLevelW-1:0]  out_level_q;
  logic [eadsr_pkg::StageW-1:0]     out_stage_q;

  logic [eadsr_pkg::TimeW-1:0]      time_sel;
  logic [33:0]                      len_prod;
  logic [NW-1:0]                    n_ext;
  logic [COUNT_WIDTH-1:0]           len_new;
  logic [eadsr_pkg::LevelW-1:0]     floor_lv, sus_lv;
  logic signed [eadsr_pkg::LogW-1:0] log_cur, d_log;
  logic [eadsr_pkg::MagW-1:0]       mag;
  logic [58:0]                      scale_prod;
  logic [61:0]                      sq_prod;
  logic [31:0]                      sq_top;
  logic [COUNT_WIDTH:0]             trial;
  logic                             qbit;
  logic signed [35:0]               f_wide;
  logic [55:0]                      tick_prod;
  logic [27:0]                      tick_lv;

  // stage length: time * rate / 1024, saturated to the counter width
  always_comb begin
    case (cmd_i.stage)
      eadsr_pkg::STG_ATTACK:  time_sel = attack_q;
      eadsr_pkg::STG_DECAY:   time_sel = decay_q;
      eadsr_pkg::STG_RELEASE: time_sel = release_q;
      default:                time_sel = '0;
    endcase
    len_prod = 34'(time_sel) * 34'(rate_q);
    n_ext    = NW'(len_prod >> 10);
    len_new  = ({1'b0, n_ext} >= CountLimit) ? '1 : n_ext[COUNT_WIDTH-1:0];
  end

  assign floor_lv = {1'b0, min_q, 8'd0};
  assign sus_lv   = {1'b0, sustain_q, 8'd0};

  // log2 of the normalized value: integer part p - 24, fraction from squaring
  assign log_cur = {6'(7'(p_q) - 7'd24), frac_q};
  assign d_log   = log_end_q - log_cur;
  assign mag     = d_log[eadsr_pkg::LogW-1] ? eadsr_pkg::MagW'(-d_log)
                                            : eadsr_pkg::MagW'(d_log);
  assign scale_prod = 59'(mag) * 59'(eadsr_pkg::Ln2Q30);

  assign sq_prod = 62'(w_q) * 62'(w_q);
  assign sq_top  = sq_prod[61:30];

  // restoring divide step
  assign trial = {rem_q, dq_q[eadsr_pkg::DivW-1]};
  assign qbit  = (trial >= {1'b0, len_q});

  assign f_wide = neg_q ? 36'(eadsr_pkg::OneQ28) - 36'(dq_q)
                        : 36'(eadsr_pkg::OneQ28) + 36'(dq_q);

  assign tick_prod = 56'(level_q) * 56'(factor_q[30:0]);
  assign tick_lv   = tick_prod[55:28];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 16'd1024;
      decay_q   <= 16'd1024;
      sustain_q <= 16'd32768;
      release_q <= 16'd1024;
      rate_q    <= 18'd48000;
      min_q     <= 16'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eadsr_pkg::REG_ATTACK:  attack_q  <= cfg_data_i[15:0];
        eadsr_pkg::REG_DECAY:   decay_q   <= cfg_data_i[15:0];
        eadsr_pkg::REG_SUSTAIN: sustain_q <= cfg_data_i[15:0];
        eadsr_pkg::REG_RELEASE: release_q <= cfg_data_i[15:0];
        eadsr_pkg::REG_RATE:    rate_q    <= cfg_data_i;
        eadsr_pkg::REG_MIN:     min_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= eadsr_pkg::STG_OFF;
      count_q  <= '0;
      len_q    <= '0;
      level_q  <= '0;
      factor_q <= eadsr_pkg::OneQ28;
    end else begin
      case (cmd_i.op)
        eadsr_pkg::DP_ENTER: begin
          stage_q  <= cmd_i.stage;
          count_q  <= '0;
          len_q    <= '0;
          factor_q <= eadsr_pkg::OneQ28;
          case (cmd_i.stage)
            eadsr_pkg::STG_OFF: level_q <= '0;
            eadsr_pkg::STG_ATTACK: begin
              len_q   <= len_new;
              level_q <= floor_lv;
            end
            eadsr_pkg::STG_DECAY: begin
              len_q   <= len_new;
              level_q <= eadsr_pkg::OneQ24;
            end
            eadsr_pkg::STG_SUSTAIN: level_q <= sus_lv;
            default: len_q <= len_new;
          endcase
        end
        eadsr_pkg::DP_FACTOR: begin
          if (f_wide > 36'sd2147483647)       factor_q <= 32'h7FFF_FFFF;
          else if (f_wide < -36'sd2147483648) factor_q <= 32'h8000_0000;
          else                                factor_q <= f_wide[31:0];
        end
        eadsr_pkg::DP_TICK: begin
          if (factor_q[31] || factor_q == '0)       level_q <= '0;
          else if (tick_lv > 28'(eadsr_pkg::OneQ24)) level_q <= eadsr_pkg::OneQ24;
          else                                       level_q <= tick_lv[24:0];
          count_q <= count_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ramp end level on entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == eadsr_pkg::DP_ENTER) begin
      case (cmd_i.stage)
        eadsr_pkg::STG_ATTACK:  end_q <= eadsr_pkg::OneQ24;
        eadsr_pkg::STG_DECAY:   end_q <= (sus_lv > floor_lv) ? sus_lv : floor_lv;
        default:                end_q <= floor_lv;
      endcase
    end
  end

  // log2, scale and divide work registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      eadsr_pkg::DP_LOAD_END: begin
        w_q    <= eadsr_pkg::NormW'(end_q) << 6;
        p_q    <= eadsr_pkg::PosTop;
        frac_q <= '0;
      end
      eadsr_pkg::DP_LOAD_START: begin
        log_end_q <= log_cur;
        w_q       <= eadsr_pkg::NormW'(level_q) << 6;
        p_q       <= eadsr_pkg::PosTop;
        frac_q    <= '0;
      end
      eadsr_pkg::DP_NORM: begin
        w_q <= w_q << 1;
        p_q <= p_q - 1'b1;
      end
      eadsr_pkg::DP_SQUARE: begin
        if (sq_top[31]) begin
          w_q    <= sq_top[31:1];
          frac_q <= {frac_q[eadsr_pkg::FracW-2:0], 1'b1};
        end else begin
          w_q    <= sq_top[30:0];
          frac_q <= {frac_q[eadsr_pkg::FracW-2:0], 1'b0};
        end
      end
      eadsr_pkg::DP_SCALE: begin
        neg_q <= d_log[eadsr_pkg::LogW-1];
        dq_q  <= scale_prod[58:26];
        rem_q <= '0;
      end
      eadsr_pkg::DP_DIV: begin
        rem_q <= qbit ? COUNT_WIDTH'(trial - {1'b0, len_q}) : trial[COUNT_WIDTH-1:0];
        dq_q  <= {dq_q[eadsr_pkg::DivW-2:0], qbit};
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_level_q <= level_q[24:8];
      out_stage_q <= stage_q;
    end
  end

  assign level_o     = out_level_q;
  assign stage_now_o = out_stage_q;

  assign status_o.norm_done    = w_q[eadsr_pkg::NormW-1];
  assign status_o.ramp_trivial = (level_q == '0) || (end_q == '0) || (len_q == '0);
  assign status_o.at_end       = (count_q == len_q);
  assign status_o.timed        = (stage_q == eadsr_pkg::STG_ATTACK) ||
                                 (stage_q == eadsr_pkg::STG_DECAY)  ||
                                 (stage_q == eadsr_pkg::STG_RELEASE);
  assign status_o.stage        = stage_q;

endmodule

FILE: rtl/eadsr_ctrl.sv
// Envelope controller: item sequencing, ramp computation steps and result handshake.
`timescale 1ns / 1ps

module eadsr_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_cmd_i,
  input  logic [eadsr_pkg::StageW-1:0]   in_target_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  eadsr_pkg::dp_status_t          status_i,
  output eadsr_pkg::dp_cmd_t             cmd_o
);

  eadsr_pkg::ctrl_state_e       state_q, state_d;
  eadsr_pkg::stage_e            enter_q, enter_d;
  logic                         tick_after_q, tick_after_d;
  logic [eadsr_pkg::StepW-1:0]  step_q, step_d;
  logic                         out_valid_q, out_valid_d;
  logic                         in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= eadsr_pkg::S_IDLE;
      enter_q      <= eadsr_pkg::STG_OFF;
      tick_after_q <= 1'b0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      enter_q      <= enter_d;
      tick_after_q <= tick_after_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    enter_d      = enter_q;
    tick_after_d = tick_after_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o.op       = eadsr_pkg::DP_NOP;
    cmd_o.stage    = enter_q;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      eadsr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i) begin
            if (in_target_i < eadsr_pkg::StageW'(eadsr_pkg::NumStages)) begin
              enter_d      = eadsr_pkg::stage_e'(in_target_i);
              tick_after_d = 1'b0;
              state_d      = eadsr_pkg::S_ENTER;
            end else begin
              state_d = eadsr_pkg::S_DONE;
            end
          end else if (status_i.timed) begin
            if (status_i.at_end) begin
              enter_d      = (status_i.stage == eadsr_pkg::STG_RELEASE) ?
                             eadsr_pkg::STG_OFF :
                             eadsr_pkg::stage_e'(status_i.stage + 1'b1);
              tick_after_d = 1'b1;
              state_d      = eadsr_pkg::S_ENTER;
            end else begin
              state_d = eadsr_pkg::S_TICK;
            end
          end else begin
            state_d = eadsr_pkg::S_DONE;
          end
        end
      end
      eadsr_pkg::S_ENTER: begin
        cmd_o.op = eadsr_pkg::DP_ENTER;
        state_d  = eadsr_pkg::S_CHECK;
      end
      eadsr_pkg::S_CHECK: begin
        if (status_i.ramp_trivial) begin
          state_d = tick_after_q ? eadsr_pkg::S_TICK : eadsr_pkg::S_DONE;
        end else begin
          cmd_o.op = eadsr_pkg::DP_LOAD_END;
          state_d  = eadsr_pkg::S_NORM_E;
        end
      end
      eadsr_pkg::S_NORM_E, eadsr_pkg::S_NORM_S: begin
        if (status_i.norm_done) begin
          step_d  = '0;
          state_d = (state_q == eadsr_pkg::S_NORM_E) ? eadsr_pkg::S_SQ_E
                                                     : eadsr_pkg::S_SQ_S;
        end else begin
          cmd_o.op = eadsr_pkg::DP_NORM;
        end
      end
      eadsr_pkg::S_SQ_E, eadsr_pkg::S_SQ_S: begin
        cmd_o.op = eadsr_pkg::DP_SQUARE;
        step_d   = step_q + 1'b1;
        if (step_q == eadsr_pkg::StepW'(eadsr_pkg::SqSteps - 1)) begin
          state_d = (state_q == eadsr_pkg::S_SQ_E) ? eadsr_pkg::S_LOAD_S
                                                   : eadsr_pkg::S_SCALE;
        end
      end
      eadsr_pkg::S_LOAD_S: begin
        cmd_o.op = eadsr_pkg::DP_LOAD_START;
        state_d  = eadsr_pkg::S_NORM_S;
      end
      eadsr_pkg::S_SCALE: begin
        cmd_o.op = eadsr_pkg::DP_SCALE;
        step_d   = '0;
        state_d  = eadsr_pkg::S_DIV;
      end
      eadsr_pkg::S_DIV: begin
        cmd_o.op = eadsr_pkg::DP_DIV;
        step_d   = step_q + 1'b1;
        if (step_q == eadsr_pkg::StepW'(eadsr_pkg::DivW - 1)) begin
          state_d = eadsr_pkg::S_FACT;
        end
      end
      eadsr_pkg::S_FACT: begin
        cmd_o.op = eadsr_pkg::DP_FACTOR;
        state_d  = tick_after_q ? eadsr_pkg::S_TICK : eadsr_pkg::S_DONE;
      end
      eadsr_pkg::S_TICK: begin
        cmd_o.op = eadsr_pkg::DP_TICK;
        state_d  = eadsr_pkg::S_DONE;
      end
      eadsr_pkg::S_DONE: begin
        // result slot free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = eadsr_pkg::S_IDLE;
        end
      end
      default: state_d = eadsr_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread result");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eadsr_pkg::S_DIV) |-> (step_q < eadsr_pkg::StepW'(eadsr_pkg::DivW)))
    else $error("divider ran past its step count");
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_cmd_i && !status_i.timed) |=> (state_q == eadsr_pkg::S_DONE))
    else $error("tick in a hold stage did not go straight to result");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/exponential_adsr_envelope_unit.sv
// Top level of the exponential ADSR envelope unit.
`timescale 1ns / 1ps

// Exponential ADSR envelope. Each input item is a sample tick (cmd 0) or an
// order to enter target_stage now (cmd 1); each item yields one result item
// with the Q1.16 level and the current stage. Items are handled one at a time.
// A tick without a stage change skips the ramp computation; a
// stage entry into attack, decay or release computes the ramp factor with a
// shared log2 unit (one squaring multiply per cycle, 24 steps per log, plus
// up to 24 normalizing shifts per log) and a one-bit-per-cycle 33-step
// divider. Entries into off or sustain, and ramps with a zero length or
// level, skip the ramp computation as well. A new item is taken while
// the previous result still waits in the output register. Register writes
// take effect at the next stage entry.
module exponential_adsr_envelope_unit #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  eadsr_in_if.sink      in_i,
  eadsr_out_if.source   out_o,
  eadsr_cfg_if.sink     cfg_i
);

  eadsr_pkg::dp_cmd_t    dp_cmd;
  eadsr_pkg::dp_status_t dp_status;

  assign cfg_i.ready = 1'b1;

  eadsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .in_target_i (in_i.target_stage),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  eadsr_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .level_o     (out_o.level),
    .stage_now_o (out_o.stage_now)
  );

endmodule

FILE: sim/exponential_adsr_envelope_unit_test.sv
// Self-checking testbench of the exponential ADSR envelope unit.
`timescale 1ns / 1ps

module exponential_adsr_envelope_unit_test;
  import eadsr_pkg::*;

  localparam int          CountW    = 24;
  localparam int          LimitCyc  = 1000000;
  localparam int          NumPhases = 6;
  localparam int          PhaseLen  = 250;
  localparam logic [2:0]  RegNone   = 3'd6;     // no register at this index
  localparam logic        CmdTick   = 1'b0;
  localparam logic        CmdEnter  = 1'b1;
  localparam logic [2:0]  BadStage  = 3'd5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  eadsr_in_if  in_ch ();
  eadsr_out_if out_ch ();
  eadsr_cfg_if cfg_ch ();

  exponential_adsr_envelope_unit #(.COUNT_WIDTH(CountW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic [OutLevelW-1:0] level;
    logic [StageW-1:0]    stage;
  } env_out_t;

  // Envelope state mirrored by the predictor
  longint unsigned atk_t, dec_t, sus_lv, rel_t, rate, floor_lv;
  longint unsigned env_stage, env_count, env_len, env_level;
  longint signed   env_factor;

  env_out_t levels_due[$];
  int       errors, n_items, n_entries, n_checked, cycles;

  // Fixed values typed into directed rows
  logic     fixed_on;
  env_out_t fixed_val;

  function automatic longint unsigned ticks_of(longint unsigned t);
    longint unsigned n;
    n = (t * rate) >> 10;
    return (n > ((64'd1 << CountW) - 1)) ? ((64'd1 << CountW) - 1) : n;
  endfunction

  // log2 of a Q1.24 level by normalization and repeated squaring, Q.24 result
  function automatic longint signed log2_level(longint unsigned x);
    int              p;
    longint unsigned m;
    longint signed   fr;
    p  = 0;
    fr = 0;
    while (p < 30 && (x >> (p + 1)) != 0) p++;
    m = (x << 30) >> p;
    for (int i = 0; i < 24; i++) begin
      m  = (m * m) >> 30;
      fr = fr * 2;
      if (m >= (64'd1 << 31)) begin
        m  = m >> 1;
        fr = fr | 1;
      end
    end
    return (longint'(p) - 24) * (64'sd1 << 24) + fr;
  endfunction

  function automatic longint signed ramp_gain(longint unsigned from_lv, longint unsigned to_lv,
                                              longint unsigned n);
    longint signed   d, f;
    longint unsigned mag, q;
    if (from_lv == 0 || to_lv == 0 || n == 0) return 64'sd1 << 28;
    d   = log2_level(to_lv) - log2_level(from_lv);
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = ((mag * 64'd744261118) >> 26) / n;
    f   = (d < 0) ? (64'sd1 << 28) - longint'(q) : (64'sd1 << 28) + longint'(q);
    if (f > 64'sd2147483647) f = 64'sd2147483647;
    if (f < -64'sd2147483648) f = -64'sd2147483648;
    return f;
  endfunction

  function automatic void start_stage(longint unsigned s);
    longint unsigned lo, sl;
    lo = floor_lv << 8;
    sl = sus_lv << 8;
    env_stage  = s;
    env_count  = 0;
    env_len    = 0;
    env_factor = 64'sd1 << 28;
    case (s)
      STG_OFF: env_level = 0;
      STG_ATTACK: begin
        env_len    = ticks_of(atk_t);
        env_level  = lo;
        env_factor = ramp_gain(env_level, 64'd1 << 24, env_len);
      end
      STG_DECAY: begin
        env_len    = ticks_of(dec_t);
        env_level  = 64'd1 << 24;
        env_factor = ramp_gain(env_level, (sl > lo) ? sl : lo, env_len);
      end
      STG_SUSTAIN: env_level = sl;
      default: begin
        env_len    = ticks_of(rel_t);
        env_factor = ramp_gain(env_level, lo, env_len);
      end
    endcase
  endfunction

  function automatic env_out_t next_level(logic cmd, logic [2:0] tgt);
    env_out_t        r;
    longint unsigned p;
    if (cmd == CmdEnter) begin
      if (tgt < NumStages) start_stage(tgt);
    end else if (env_stage != STG_OFF && env_stage != STG_SUSTAIN) begin
      if (env_count == env_len) start_stage((env_stage + 1) % NumStages);
      if (env_factor <= 0) begin
        env_level = 0;
      end else begin
        p = (env_level * longint'(env_factor)) >> 28;
        env_level = (p > (64'd1 << 24)) ? (64'd1 << 24) : p;
      end
      env_count = (env_count + 1) & ((64'd1 << CountW) - 1);
    end
    r.level = OutLevelW'(env_level >> 8);
    r.stage = StageW'(env_stage);
    return r;
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [CfgDataW-1:0] v);
    case (idx)
      REG_ATTACK:  atk_t    = v[15:0];
      REG_DECAY:   dec_t    = v[15:0];
      REG_SUSTAIN: sus_lv   = v[15:0];
      REG_RELEASE: rel_t    = v[15:0];
      REG_RATE:    rate     = v[17:0];
      REG_MIN:     floor_lv = v[15:0];
      default: ;
    endcase
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH item %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  // Monitor: check results first, then predict for the item taken at this edge
  always @(posedge clk_i) begin
    env_out_t e, got;
    cycles++;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (levels_due.size() == 0) begin
        errors++;
        $display("MISMATCH: result with no item waiting");
      end else begin
        e = levels_due.pop_front();
        if (out_ch.level !== e.level) report("level", out_ch.level, e.level);
        if (out_ch.stage_now !== e.stage) report("stage_now", out_ch.stage_now, e.stage);
      end
      n_checked++;
    end
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) set_reg(cfg_ch.index, cfg_ch.data);
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      got = next_level(in_ch.cmd, in_ch.target_stage);
      levels_due.push_back(fixed_on ? fixed_val : got);
      n_items++;
      if (in_ch.cmd == CmdEnter) n_entries++;
    end
  end

  // Receiver stalls: always ready, random, or a fixed on/off pattern
  always @(posedge clk_i) begin
    case ((cycles / 300) % 3)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= (cycles % 5) < 2;
    endcase
  end

  always @(posedge clk_i) begin
    if (cycles >= LimitCyc) begin
      $display("timeout after %0d cycles", cycles);
      $display("exponential_adsr_envelope_unit_test failed");
      $finish;
    end
  end

  int burst_left;

  // Send one item; valid stays high inside a burst, drops for a gap
  task automatic send_item(logic cmd, logic [2:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.target_stage <= tgt;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CfgDataW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_setting(logic [CfgDataW-1:0] a, logic [CfgDataW-1:0] d,
                              logic [CfgDataW-1:0] s, logic [CfgDataW-1:0] r,
                              logic [CfgDataW-1:0] sr, logic [CfgDataW-1:0] m);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_SUSTAIN, s);
    write_reg(REG_RELEASE, r);
    write_reg(REG_RATE, sr);
    write_reg(REG_MIN, m);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  typedef struct {
    logic                 cmd;
    logic [2:0]           tgt;
    logic                 typed;
    logic [OutLevelW-1:0] lv;
    logic [StageW-1:0]    st;
  } dir_row_t;

  // Directed rows; attack has zero length, decay 2 and release 3 ticks here
  dir_row_t dir_rows[] = '{
    '{CmdTick,  STG_OFF,     1, 0,     STG_OFF},
    '{CmdEnter, 3'd7,        1, 0,     STG_OFF},
    '{CmdEnter, STG_OFF,     1, 0,     STG_OFF},
    '{CmdEnter, STG_SUSTAIN, 1, 32768, STG_SUSTAIN},
    '{CmdTick,  STG_OFF,     1, 32768, STG_SUSTAIN},
    '{CmdEnter, BadStage,    1, 32768, STG_SUSTAIN},
    '{CmdEnter, 3'd6,        1, 32768, STG_SUSTAIN},
    '{CmdEnter, STG_ATTACK,  1, 7,     STG_ATTACK},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdEnter, STG_DECAY,   1, 65536, STG_DECAY},
    '{CmdEnter, STG_RELEASE, 1, 65536, STG_RELEASE},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     0, 0,     STG_OFF},
    '{CmdTick,  STG_OFF,     1, 0,     STG_OFF},
    '{CmdEnter, STG_RELEASE, 1, 0,     STG_RELEASE},
    '{CmdTick,  STG_OFF,     1, 0,     STG_RELEASE},
    '{CmdEnter, STG_OFF,     1, 0,     STG_OFF}
  };

  initial begin
    logic [2:0] tgt;
    in_ch.valid = 1'b0;  in_ch.cmd = 1'b0;  in_ch.target_stage = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    fixed_on = 1'b0;
    errors = 0; n_items = 0; n_entries = 0; n_checked = 0; cycles = 0; burst_left = 0;
    atk_t = 1024; dec_t = 1024; sus_lv = 32768; rel_t = 1024; rate = 48000; floor_lv = 7;
    env_stage = STG_OFF; env_count = 0; env_len = 0; env_level = 0;
    env_factor = 64'sd1 << 28;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: rate 1024 makes the stage length equal to the time value
    load_setting(0, 2, 32768, 3, 1024, 7);
    foreach (dir_rows[i]) begin
      // updated after the monitor has seen the previous item at this edge
      fixed_on        <= dir_rows[i].typed;
      fixed_val.level <= dir_rows[i].lv;
      fixed_val.stage <= dir_rows[i].st;
      send_item(dir_rows[i].cmd, dir_rows[i].tgt);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    fixed_on <= 1'b0;
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: load_setting(65535, 65535, 65535, 65535, 192000, 65535);
        1: load_setting(1023, 1023, 0, 1023, 1, 1);
        2: load_setting(18'h30005, 18'h10003, 18'h30000, 18'h20004, 1024, 18'h30000);
        default: load_setting(CfgDataW'($urandom_range(0, 40)),
                              CfgDataW'($urandom_range(0, 40)),
                              CfgDataW'($urandom), CfgDataW'($urandom_range(0, 40)),
                              CfgDataW'($urandom_range(1000, 1100)),
                              CfgDataW'($urandom_range(1, 65535)));
      endcase
      if (ph == 3) begin
        write_reg(RegNone, CfgDataW'($urandom));
        write_reg(3'd7, CfgDataW'($urandom));
        cfg_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
      for (int k = 0; k < PhaseLen; k++) begin
        if ($urandom_range(0, 99) < 80) begin
          send_item(CmdTick, 3'($urandom));
        end else begin
          tgt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
          send_item(CmdEnter, tgt);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d items (%0d stage orders), %0d results checked", n_items, n_entries,
             n_checked);
    $display("over %0d register settings including the extremes", NumPhases + 1);
    if (errors == 0 && levels_due.size() == 0) begin
      $display("exponential_adsr_envelope_unit_test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, levels_due.size());
      $display("exponential_adsr_envelope_unit_test failed");
    end
    $finish;
  end

endmodule

FILE: exponential_adsr_envelope_unit.f
rtl/eadsr_pkg.sv
rtl/eadsr_if.sv
rtl/eadsr_dp.sv
rtl/eadsr_ctrl.sv
rtl/exponential_adsr_envelope_unit.sv
sim/exponential_adsr_envelope_unit_test.sv
